[design/heavy_hitter_decay_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Heavy hitter decay table - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef HEAVY_HITTER_DECAY_TABLE_CORE_ASSERT_SVH
`define HEAVY_HITTER_DECAY_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define HHDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HHDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hhdt_pkg.sv]
// ----------------------------------------------------------------------------
// hhdt_pkg
// Types, hash constants and the decay threshold table.
// ----------------------------------------------------------------------------
package hhdt_pkg;

    localparam int KEY_BITS = 104;

    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_C3  = 32'h85ebca6b;
    localparam logic [31:0] MM_C4  = 32'hc2b2ae35;
    localparam logic [31:0] MM_ADD = 32'he6546b64;
    localparam logic [31:0] MM_LEN = 32'd13;

    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;
    localparam logic [31:0] DECAY_LIMIT = 32'd400;

    typedef enum logic [2:0] {
        ST_PLACED    = 3'd0,
        ST_MATCHED   = 3'd1,
        ST_DECAYED   = 3'd2,
        ST_REPLACED  = 3'd3,
        ST_UNCHANGED = 3'd4,
        ST_READ      = 3'd5
    } t_status;

    typedef struct packed {
        logic [31:0] count;
        logic [39:0] key_high;
        logic [63:0] key_low;
    } t_cell;

    typedef logic [31:0] t_thr_rom [512];

    // (25/27)^c in Q6.58, kept as Q0.32; zero beyond the decay limit
    function automatic t_thr_rom build_thr();
        logic [63:0] p;
        t_thr_rom    t;
        p = 64'd1 << 58;
        t[0] = COUNT_MAX;
        for (int i = 1; i < 512; i++) begin
            p = (p * 64'd25) / 64'd27;
            t[i] = (i <= 400) ? p[57:26] : 32'd0;
        end
        return t;
    endfunction

    localparam t_thr_rom THR_ROM = build_thr();

endpackage

[design/hhdt_store.sv]
// ----------------------------------------------------------------------------
// hhdt_store
// Cell memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hhdt_store #(
    parameter int AW = 14
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  hhdt_pkg::t_cell i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output hhdt_pkg::t_cell o_rdata
);

    hhdt_pkg::t_cell r_mem [2**AW];
    hhdt_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/hhdt_hash.sv]
// ----------------------------------------------------------------------------
// hhdt_hash
// Key hash over one shared 32x32 multiplier, then reciprocal-multiply bucket
// remainder on the same multiplier with one compare and subtract.
// ----------------------------------------------------------------------------
module hhdt_hash #(
    parameter int BUCKETS = 2048,
    parameter int BW      = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hhdt_pkg::KEY_BITS-1:0] i_key,
    output logic                          o_done,
    output logic [BW-1:0]                 o_bucket
);

    localparam int RW = BW + 1;
    localparam logic [RW-1:0] BUCK_C = RW'(BUCKETS);
    localparam logic [31:0] BUCK32 = 32'(BUCKETS);
    // floor(2^32 / BUCKETS), held to 32 bits; quotient estimate is low by at most one
    localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(BUCKETS);
    localparam logic [31:0] RECIP = (RECIP64 > 64'h00000000FFFFFFFF) ? 32'hFFFFFFFF :
                                    RECIP64[31:0];
    localparam logic [5:0] LAST_STEP = 6'd19;

    logic [hhdt_pkg::KEY_BITS-1:0] r_key;
    logic [31:0] r_prod, r_h, n_h, w_a, w_b, w_word, w_x, w_y, w_diff;
    logic [63:0] w_full;
    logic        w_mul, w_hi;
    logic [5:0]  r_step;
    logic        r_busy, r_done;
    logic [RW-1:0] r_rem, n_rem, w_t;

    always_comb begin
        unique case (r_step[3:2])
            2'd0:    w_word = r_key[31:0];
            2'd1:    w_word = r_key[63:32];
            2'd2:    w_word = r_key[95:64];
            default: w_word = {24'd0, r_key[103:96]};
        endcase
        w_x = r_h ^ r_prod ^ hhdt_pkg::MM_LEN;
        w_y = r_h ^ r_prod;
        w_diff = r_h - r_prod;
        w_t = w_diff[RW-1:0];
        w_a = r_prod;
        w_b = hhdt_pkg::MM_C1;
        w_mul = 1'b0;
        w_hi = 1'b0;
        n_h = r_h;
        n_rem = r_rem;
        if (r_step >= 6'd17) begin
            unique case (r_step)
                6'd17: begin
                    w_a = r_h; w_b = RECIP; w_mul = 1'b1; w_hi = 1'b1;
                end
                6'd18: begin
                    w_a = r_prod; w_b = BUCK32; w_mul = 1'b1;
                end
                default: begin
                    n_rem = (w_t >= BUCK_C) ? w_t - BUCK_C : w_t;
                end
            endcase
        end else begin
            unique case (r_step)
                6'd0, 6'd4, 6'd8, 6'd12: begin
                    w_a = w_word; w_b = hhdt_pkg::MM_C1; w_mul = 1'b1;
                end
                6'd1, 6'd5, 6'd9, 6'd13: begin
                    w_a = {r_prod[16:0], r_prod[31:17]}; w_b = hhdt_pkg::MM_C2; w_mul = 1'b1;
                end
                6'd2, 6'd6, 6'd10: begin
                    w_a = {w_y[18:0], w_y[31:19]}; w_b = 32'd5; w_mul = 1'b1;
                end
                6'd3, 6'd7, 6'd11: begin
                    n_h = r_prod + hhdt_pkg::MM_ADD;
                end
                6'd14: begin
                    w_a = w_x ^ (w_x >> 16); w_b = hhdt_pkg::MM_C3; w_mul = 1'b1;
                end
                6'd15: begin
                    w_a = r_prod ^ (r_prod >> 13); w_b = hhdt_pkg::MM_C4; w_mul = 1'b1;
                end
                default: begin
                    n_h = r_prod ^ (r_prod >> 16);
                    n_rem = '0;
                end
            endcase
        end
    end

    assign w_full = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_h   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_h   <= n_h;
            r_rem <= n_rem;
            if (w_mul) begin
                r_prod <= w_hi ? w_full[63:32] : w_full[31:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BW-1:0];

endmodule

[design/heavy_hitter_decay_table_core.sv]
// Insert: hash the key (S_HASH), then read and check the bucket cells in turn (S_RD, S_EV)
// until an empty or matching cell; if none, look up the threshold (S_THR) and decay (S_DEC).
// S_OUT then loads the output. Read: S_RDOP, then S_OUT. One word in flight; the next is
// taken in the cycle after the result is loaded. Reset (i_rst_n low, synchronous) clears all
// 2**(bucket bits + cell bits) cells, 16384 by default; no word is accepted meanwhile.
// ----------------------------------------------------------------------------
// heavy_hitter_decay_table_core
// Heavy hitter table with exponential decay, one bucket cell per memory access.
// ----------------------------------------------------------------------------
module heavy_hitter_decay_table_core #(
    parameter int BUCKETS          = 2048,
    parameter int CELLS_PER_BUCKET = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // key_low[63:0], key_high[103:64], random_draw[135:104],
    // read_bucket[146:136], read_cell[149:147]
    input  logic [151:0] i_s_tdata,
    // operation[0]
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // bucket_out[10:0], cell_out[13:11], count_out[45:14],
    // key_low_out[109:46], key_high_out[149:110]
    output logic [151:0] o_m_tdata,
    // status[2:0]
    output logic [2:0]   o_m_tuser
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;
    localparam int AW = BW + CW;
    localparam logic [CW-1:0] LAST_CELL = CW'(CELLS_PER_BUCKET - 1);
    localparam logic [16:0] BUCK17 = 17'(BUCKETS);
    localparam logic [4:0]  CELL5  = 5'(CELLS_PER_BUCKET);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_EV    = 9'b000010000,
        S_THR   = 9'b000100000,
        S_DEC   = 9'b001000000,
        S_RDOP  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [63:0] r_key_low;
    logic [39:0] r_key_high;
    logic [31:0] r_draw, r_thr;
    logic        r_op;
    logic [10:0] r_rb;
    logic [2:0]  r_rc;
    logic [BW-1:0] r_bucket;
    logic [CW-1:0] r_cell, r_min_cell, r_res_cell;
    logic [AW-1:0] r_clr;
    hhdt_pkg::t_cell r_min, r_res;
    hhdt_pkg::t_status r_status;
    logic        r_in_range;
    logic        r_rd_pend;

    logic        r_m_valid;
    logic [151:0] r_m_data;
    logic [2:0]  r_m_user;

    logic        w_accept, w_load, w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    hhdt_pkg::t_cell w_wdata, w_rdata, w_new;
    logic        w_hash_done;
    logic [BW-1:0] w_hash_bucket;
    logic        w_match, w_decay;
    logic [8:0]  w_thr_addr;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_OUT) && !r_rd_pend && (!r_m_valid || i_m_tready);

    hhdt_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && !i_s_tuser),
        .i_key    (i_s_tdata[103:0]),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bucket)
    );

    hhdt_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_match = (w_rdata.key_low == r_key_low) && (w_rdata.key_high == r_key_high);
    assign w_decay = r_draw < r_thr;
    assign w_thr_addr = (r_min.count > hhdt_pkg::DECAY_LIMIT) ? 9'h1FF : r_min.count[8:0];

    always_comb begin
        w_re    = 1'b0;
        w_raddr = {r_bucket, r_cell};
        w_we    = 1'b0;
        w_waddr = {r_bucket, r_cell};
        w_new   = r_min;
        unique case (r_state)
            S_RD: begin
                w_re = 1'b1;
            end
            S_RDOP: begin
                w_re    = 1'b1;
                w_raddr = {BW'(r_rb), CW'(r_rc)};
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_new   = '0;
            end
            S_EV: begin
                if (w_rdata.count == '0) begin
                    w_we  = 1'b1;
                    w_new = '{count: 32'd1, key_high: r_key_high, key_low: r_key_low};
                end else if (w_match) begin
                    w_we  = 1'b1;
                    w_new = w_rdata;
                    if (w_rdata.count != hhdt_pkg::COUNT_MAX) begin
                        w_new.count = w_rdata.count + 32'd1;
                    end
                end
            end
            S_DEC: begin
                w_waddr = {r_bucket, r_min_cell};
                if (w_decay) begin
                    w_we = 1'b1;
                    if (r_min.count > 32'd1) begin
                        w_new.count = r_min.count - 32'd1;
                    end else begin
                        w_new.key_low  = r_key_low;
                        w_new.key_high = r_key_high;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_wdata = w_new;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) n_state = i_s_tuser ? S_RDOP : S_HASH;
            end
            S_HASH:  if (w_hash_done) n_state = S_RD;
            S_RD:    n_state = S_EV;
            S_EV: begin
                if (w_rdata.count == '0 || w_match) begin
                    n_state = S_OUT;
                end else if (r_cell == LAST_CELL) begin
                    n_state = S_THR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_THR:   n_state = S_DEC;
            S_DEC:   n_state = S_OUT;
            S_RDOP:  n_state = S_OUT;
            S_OUT:   if (w_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // read-op result is taken in the cycle after the read is issued, in S_OUT entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == S_RDOP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_s_tuser;
            r_key_low  <= i_s_tdata[63:0];
            r_key_high <= i_s_tdata[103:64];
            r_draw     <= i_s_tdata[135:104];
            r_rb       <= i_s_tdata[146:136];
            r_rc       <= i_s_tdata[149:147];
            r_in_range <= (17'(i_s_tdata[146:136]) < BUCK17) &&
                          (5'(i_s_tdata[149:147]) < CELL5);
        end
        if (r_state == S_HASH && w_hash_done) begin
            r_bucket <= w_hash_bucket;
            r_cell   <= '0;
        end
        if (r_state == S_EV) begin
            r_res_cell <= r_cell;
            r_res      <= w_new;
            if (w_rdata.count == '0) begin
                r_status <= hhdt_pkg::ST_PLACED;
            end else if (w_match) begin
                r_status <= hhdt_pkg::ST_MATCHED;
            end else begin
                if (r_cell == '0 || w_rdata.count < r_min.count) begin
                    r_min      <= w_rdata;
                    r_min_cell <= r_cell;
                end
                r_cell <= r_cell + CW'(1);
            end
        end
        if (r_state == S_THR) begin
            r_thr <= hhdt_pkg::THR_ROM[w_thr_addr];
        end
        if (r_state == S_DEC) begin
            r_res_cell <= r_min_cell;
            r_res      <= w_new;
            priority if (!w_decay) begin
                r_status <= hhdt_pkg::ST_UNCHANGED;
            end else if (r_min.count > 32'd1) begin
                r_status <= hhdt_pkg::ST_DECAYED;
            end else begin
                r_status <= hhdt_pkg::ST_REPLACED;
            end
        end
        if (r_rd_pend) begin
            r_status <= hhdt_pkg::ST_READ;
            r_res    <= r_in_range ? w_rdata : '0;
        end
        if (w_load) begin
            r_m_user <= r_status;
            if (r_op) begin
                r_m_data <= {2'b00, r_res.key_high, r_res.key_low, r_res.count, r_rc, r_rb};
            end else begin
                r_m_data <= {2'b00, r_res.key_high, r_res.key_low, r_res.count,
                             3'(r_res_cell), 11'(r_bucket)};
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

`include "heavy_hitter_decay_table_core_assert.svh"

    `HHDT_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_s_tready, "word accepted while busy")
    `HHDT_ASSERT_NOW(a_write_states, w_we, (r_state == S_CLEAR) || (r_state == S_EV) || (r_state == S_DEC), "memory write outside update states")
    `HHDT_ASSERT_NOW(a_hash_done_state, w_hash_done, r_state == S_HASH, "hash finished outside hash wait")
    `HHDT_ASSERT_NEXT(a_load_valid, w_load, o_m_tvalid, "loaded result not presented")

endmodule
